@@ hdl/rls_pkg.sv @@
// Shared types and constants for the radix-4 LSD sorter.
package rls_pkg;

  // Width of a key on the ports
  localparam int unsigned KEY_W = 8;

  // Input word: one key, with the final key of the set marked
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last_key;
  } in_word_t;

  // Output word: next key in ascending order, final one marked
  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             last_sorted;
  } out_word_t;

  // Commands from the sequencer to the digit counter bank
  typedef struct packed {
    logic clear;  // zero all counters and the prefix accumulator
    logic inc;    // count one occurrence of the selected digit
    logic dec;    // take one from the selected digit (scatter)
    logic accum;  // prefix-sum step at the selected digit
  } cnt_ctl_t;

endpackage

@@ hdl/rls_count.sv @@
// Digit counter bank: per-digit counts, running prefix sum and scatter decrement.
module rls_count
  import rls_pkg::*;
#(
  parameter int unsigned DIGIT_BITS = 2,
  parameter int unsigned CNT_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cnt_ctl_t              ctl,
  input  logic [DIGIT_BITS-1:0] sel,
  output logic [CNT_W-1:0]      cnt_o
);

  localparam int unsigned RADIX = 1 << DIGIT_BITS;

  logic [CNT_W-1:0] cnt_r [RADIX];
  logic [CNT_W-1:0] acc_r;
  logic [CNT_W-1:0] acc_nxt;

  // Count of the selected digit
  assign cnt_o   = cnt_r[sel];
  // Running sum for the prefix step
  assign acc_nxt = acc_r + cnt_r[sel];

  // Counter updates; one command per cycle
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < RADIX; i++) begin
        cnt_r[i] <= '0;
      end
      acc_r <= '0;
    end else begin
      if (ctl.inc) begin
        cnt_r[sel] <= cnt_r[sel] + CNT_W'(1);
      end
      if (ctl.dec) begin
        cnt_r[sel] <= cnt_r[sel] - CNT_W'(1);
      end
      if (ctl.accum) begin
        cnt_r[sel] <= acc_nxt;
        acc_r      <= acc_nxt;
      end
    end
  end

  // Commands never collide
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.inc && ctl.dec) && !(ctl.inc && ctl.accum) && !(ctl.dec && ctl.accum))
    else $error("rls_count: more than one counter command at once");

  // Scatter never takes from an empty digit
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dec |-> cnt_o != '0)
    else $error("rls_count: decrement of a zero count");

  // Clear leaves the accumulator at zero
  a_clear_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> acc_r == '0)
    else $error("rls_count: accumulator not cleared");

endmodule

@@ hdl/radix4_lsd_sorter.sv @@
// Radix-4 LSD sorter: up to CAPACITY keys in, sorted keys out; sequencer over two key memories.
// Load: one word per cycle while in_ready is high. Sort: ceil(KEY_BITS/DIGIT_BITS)
// passes, each made of count, prefix, scatter and copy steps. Emit: each word is read
// from the key memory and then loaded into the output register; the read waits until
// that register is free. Input is closed from the final key until the last word is loaded.
// Reset (rst_n, synchronous) clears control state and counters; memories are not cleared.
module radix4_lsd_sorter
  import rls_pkg::*;
#(
  parameter int unsigned CAPACITY   = 8,
  parameter int unsigned KEY_BITS   = 8,
  parameter int unsigned DIGIT_BITS = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int unsigned AW         = $clog2(CAPACITY);
  localparam int unsigned CW         = $clog2(CAPACITY + 1);
  localparam int unsigned PASS_COUNT = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PW         = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;
  localparam int unsigned SHW        = 6;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_BITS) - 1);

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_COUNT   = 8'b0000_0010,
    S_PREFIX  = 8'b0000_0100,
    S_SCATTER = 8'b0000_1000,
    S_COPY    = 8'b0001_0000,
    S_EMIT_RD = 8'b0010_0000,
    S_EMIT_LD = 8'b0100_0000,
    S_SPARE   = 8'b1000_0000
  } state_t;

  // Digit of a key for the current pass
  function automatic logic [DIGIT_BITS-1:0] digit_of(logic [KEY_W-1:0] k,
                                                     logic [SHW-1:0] sh);
    logic [31:0] kx;
    kx = 32'(k) >> sh;
    return kx[DIGIT_BITS-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [DIGIT_BITS-1:0] pfx_r, pfx_nxt;
  logic [PW-1:0]       pass_r, pass_nxt;
  logic [SHW-1:0]      shamt_r, shamt_nxt;
  logic                proc_r, proc_nxt;
  logic [AW-1:0]       proc_addr_r;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r;

  logic [KEY_W-1:0]    key_mem [CAPACITY];
  logic [KEY_W-1:0]    scat_mem [CAPACITY];
  logic [KEY_W-1:0]    key_rdata_r, scat_rdata_r;

  logic                key_we, key_re, scat_we, scat_re;
  logic [AW-1:0]       key_waddr, key_raddr, scat_waddr, scat_raddr;
  logic [KEY_W-1:0]    key_wdata;

  logic                in_acc, out_load, issue, last_emit, last_pass;
  logic [CW-1:0]       ptr_dec, ptr_inc, cnt_dec;
  logic [CW-1:0]       cnt_val;
  cnt_ctl_t            cnt_ctl;
  logic [DIGIT_BITS-1:0] cnt_sel;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign ptr_dec   = ptr_r - CW'(1);
  assign ptr_inc   = ptr_r + CW'(1);
  assign cnt_dec   = cnt_val - CW'(1);
  assign last_emit = (ptr_inc == fill_r);
  assign last_pass = (pass_r == PW'(PASS_COUNT - 1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Digit counter bank
  rls_count #(
    .DIGIT_BITS (DIGIT_BITS),
    .CNT_W      (CW)
  ) u_count (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cnt_ctl),
    .sel   (cnt_sel),
    .cnt_o (cnt_val)
  );

  // Sequencer and memory port control
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    pfx_nxt    = pfx_r;
    pass_nxt   = pass_r;
    shamt_nxt  = shamt_r;
    issue      = 1'b0;
    out_load   = 1'b0;
    key_we     = 1'b0;
    key_waddr  = fill_r[AW-1:0];
    key_wdata  = in_data.key & KEY_MASK;
    key_re     = 1'b0;
    key_raddr  = ptr_r[AW-1:0];
    scat_we    = 1'b0;
    scat_waddr = cnt_dec[AW-1:0];
    scat_re    = 1'b0;
    scat_raddr = ptr_r[AW-1:0];
    cnt_ctl    = '0;
    cnt_sel    = digit_of(key_rdata_r, shamt_r);

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (fill_r < CW'(CAPACITY)) begin
            key_we   = 1'b1;
            fill_nxt = fill_r + CW'(1);
          end
          if (in_data.last_key) begin
            cnt_ctl.clear = 1'b1;
            pass_nxt      = '0;
            shamt_nxt     = '0;
            ptr_nxt       = '0;
            state_nxt     = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        // read keys in order, count each digit in the following cycle
        cnt_ctl.inc = proc_r;
        if (ptr_r != fill_r) begin
          issue   = 1'b1;
          key_re  = 1'b1;
          ptr_nxt = ptr_inc;
        end else if (!proc_r) begin
          pfx_nxt   = '0;
          state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cnt_ctl.accum = 1'b1;
        cnt_sel       = pfx_r;
        pfx_nxt       = pfx_r + DIGIT_BITS'(1);
        if (pfx_r == {DIGIT_BITS{1'b1}}) begin
          ptr_nxt   = fill_r;
          state_nxt = S_SCATTER;
        end
      end
      S_SCATTER: begin
        // read keys from the back, place at prefix position minus one
        cnt_ctl.dec = proc_r;
        scat_we     = proc_r;
        key_raddr   = ptr_dec[AW-1:0];
        if (ptr_r != '0) begin
          issue   = 1'b1;
          key_re  = 1'b1;
          ptr_nxt = ptr_dec;
        end else if (!proc_r) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // copy scatter buffer back into the key memory
        key_we    = proc_r;
        key_waddr = proc_addr_r;
        key_wdata = scat_rdata_r;
        if (ptr_r != fill_r) begin
          issue   = 1'b1;
          scat_re = 1'b1;
          ptr_nxt = ptr_inc;
        end else if (!proc_r) begin
          ptr_nxt = '0;
          if (last_pass) begin
            state_nxt = S_EMIT_RD;
          end else begin
            cnt_ctl.clear = 1'b1;
            pass_nxt      = pass_r + PW'(1);
            shamt_nxt     = shamt_r + SHW'(DIGIT_BITS);
            state_nxt     = S_COUNT;
          end
        end
      end
      S_EMIT_RD: begin
        // fetch next word once the output register frees up
        if (!out_valid_r || out_ready) begin
          key_re    = 1'b1;
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        out_load = 1'b1;
        if (last_emit) begin
          fill_nxt  = '0;
          pass_nxt  = '0;
          shamt_nxt = '0;
          state_nxt = S_LOAD;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign proc_nxt = issue;

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      ptr_r       <= '0;
      pfx_r       <= '0;
      pass_r      <= '0;
      shamt_r     <= '0;
      proc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      pfx_r       <= pfx_nxt;
      pass_r      <= pass_nxt;
      shamt_r     <= shamt_nxt;
      proc_r      <= proc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    proc_addr_r <= ptr_r[AW-1:0];
    if (out_load) begin
      out_data_r.sorted_key  <= key_rdata_r;
      out_data_r.last_sorted <= last_emit;
    end
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (key_re) begin
      key_rdata_r <= key_mem[key_raddr];
    end
  end

  // Scatter memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (scat_we) begin
      scat_mem[scat_waddr] <= key_rdata_r;
    end
    if (scat_re) begin
      scat_rdata_r <= scat_mem[scat_raddr];
    end
  end

  // Store never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("radix4_lsd_sorter: fill count beyond capacity");

  // Final key closes the input
  a_mark_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_key) |=> !in_ready)
    else $error("radix4_lsd_sorter: input open after final key");

  // Last word loaded hands back an empty store
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_emit) |=> (fill_r == '0 && in_ready && out_valid_r))
    else $error("radix4_lsd_sorter: store not released after last word");

  // Output register is free whenever a word is loaded
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r)
    else $error("radix4_lsd_sorter: output word overwritten");

endmodule

@@ tb/sv/tb_radix4_lsd_sorter.sv @@
// Testbench for the radix-4 LSD sorter: key sets in, sorted words checked against a local sort.
`timescale 1ns / 1ps

module tb_radix4_lsd_sorter;
  import rls_pkg::*;

  localparam int unsigned SET_CAP    = 8;
  localparam int unsigned KEY_BITS   = 8;
  localparam int unsigned DIGIT_BITS = 2;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 1);
  localparam int unsigned RANDOM_ITEMS = 345;
  // sort takes 4 passes before the sorted words are emitted
  localparam int unsigned SETTLE_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // predictor state: keys held for the current set
  logic [KEY_W-1:0] held_keys [SET_CAP];
  int unsigned      held_count = 0;
  out_word_t        sorted_expect[$];

  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned ready_left = 0;

  radix4_lsd_sorter #(
    .CAPACITY  (SET_CAP),
    .KEY_BITS  (KEY_BITS),
    .DIGIT_BITS(DIGIT_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Store an accepted key; on the final key sort the set and queue its words
  function automatic void predict_sorted(in_word_t w);
    logic [KEY_W-1:0] ordered [SET_CAP];
    logic [KEY_W-1:0] tmp;
    out_word_t        ow;
    int               j;
    if (held_count < SET_CAP) begin
      held_keys[held_count] = w.key & KEY_MASK;
      held_count++;
    end
    if (!w.last_key) return;
    for (int i = 0; i < held_count; i++) ordered[i] = held_keys[i];
    // plain insertion sort; equal keys are indistinguishable so stability is moot
    for (int i = 1; i < held_count; i++) begin
      tmp = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > tmp) begin
        ordered[j+1] = ordered[j];
        j--;
      end
      ordered[j+1] = tmp;
    end
    for (int i = 0; i < held_count; i++) begin
      ow.sorted_key  = ordered[i];
      ow.last_sorted = (i == held_count - 1);
      sorted_expect.push_back(ow);
    end
    held_count = 0;
  endfunction

  // Offer one word, with bursty gaps, and wait for it to be taken
  task automatic send_word(logic [KEY_W-1:0] key, logic last);
    in_word_t w;
    w.key      = key;
    w.last_key = last;
    if (!no_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    predict_sorted(w);
  endtask

  // Hold off input until every queued word has come out
  task automatic drain_sorted();
    in_valid <= 1'b0;
    do @(posedge clk); while (sorted_expect.size() != 0);
  endtask

  // Output side stalls on a pattern of runs: long ready, stalls, and toggling
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready  <= 1'b1;
          ready_left <= $urandom_range(40, 120);
        end
        1: begin
          out_ready  <= 1'b0;
          ready_left <= $urandom_range(1, 10);
        end
        default: begin
          out_ready  <= 1'($urandom_range(0, 1));
          ready_left <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_expect.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected word: key=%0d last=%0b", out_data.sorted_key,
                   out_data.last_sorted);
        fail_count++;
      end else begin
        want = sorted_expect.pop_front();
        if (out_data.sorted_key !== want.sorted_key ||
            out_data.last_sorted !== want.last_sorted) begin
          if (fail_count < 10)
            $display("mismatch: key exp=%0d got=%0d, last exp=%0b got=%0b",
                     want.sorted_key, out_data.sorted_key, want.last_sorted,
                     out_data.last_sorted);
          fail_count++;
        end
      end
    end
  end

  // Random key, weighted toward duplicates and extremes
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1: return KEY_W'($urandom_range(0, 7));
      2:    return ($urandom_range(0, 1)) ? '0 : '1;
      3:    return KEY_W'($urandom_range(248, 255));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic test_single_key();
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_full_set_extremes();
    logic [KEY_W-1:0] keys [SET_CAP] = '{8'd255, 8'd0, 8'd128, 8'd127,
                                         8'd1, 8'd254, 8'd170, 8'd85};
    no_gaps = 1'b1;
    for (int i = 0; i < SET_CAP; i++) send_word(keys[i], i == SET_CAP - 1);
    no_gaps = 1'b0;
  endtask

  task automatic test_duplicates();
    send_word(8'd3, 1'b0);
    send_word(8'd3, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd3, 1'b1);
  endtask

  // Two keys past capacity; the final one arrives while full and is dropped
  task automatic test_overflow();
    for (int i = 0; i < SET_CAP + 2; i++)
      send_word(KEY_W'(200 - 23 * i), i == SET_CAP + 1);
  endtask

  task automatic test_random_sets();
    int unsigned sent = 0;
    int unsigned set_no = 0;
    int unsigned set_len;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    set_len = SET_CAP;
        2:       set_len = $urandom_range(SET_CAP + 1, SET_CAP + 4);
        default: set_len = $urandom_range(1, SET_CAP);
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < set_len; i++) send_word(pick_key(), i == set_len - 1);
      sent += set_len;
      set_no++;
      // let the output side empty now and then before the next set
      if (set_no % 8 == 3) drain_sorted();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_key();
    test_full_set_extremes();
    test_duplicates();
    test_overflow();
    test_random_sets();
    drain_sorted();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && sorted_expect.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rls_pkg.sv
hdl/rls_count.sv
hdl/radix4_lsd_sorter.sv
tb/sv/tb_radix4_lsd_sorter.sv
